// ===== src/torus_grid_neighbour_walker_core_defines.svh =====
// Assertion macros for the torus grid neighbour walker.
// Included by the RTL files that carry concurrent checks; needs no other file.
`ifndef TORUS_GRID_NEIGHBOUR_WALKER_CORE_DEFINES_SVH
`define TORUS_GRID_NEIGHBOUR_WALKER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TGNW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TGNW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TGNW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TGNW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/tgnw_pkg.sv =====
// Shared types and constants of the torus grid neighbour walker.
// No dependencies; used by the result channel interface, the offset evaluator and the core.
`default_nettype none
package tgnw_pkg;

  localparam int OUT_COORD_W = 8;   // coordinate width on the result channel
  localparam int OUT_DIMS    = 3;   // coordinate fields per result
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int DIMS_W      = 2;
  localparam int GRID_W      = 9;
  localparam int DIST_W      = 2;

  localparam logic [DIMS_W-1:0] DIMS_RST  = 2'd3;
  localparam logic [GRID_W-1:0] GRID_RST  = 9'd4;
  localparam logic              TORUS_RST = 1'b1;
  localparam logic [DIST_W-1:0] MIN_RST   = 2'd1;
  localparam logic [DIST_W-1:0] MAX_RST   = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMS  = 3'd0,
    CFG_GRID  = 3'd1,
    CFG_TORUS = 3'd2,
    CFG_MIN   = 3'd3,
    CFG_MAX   = 3'd4
  } cfg_idx_t;

  // one offset digit: -1, 0 or +1
  typedef enum logic [1:0] {
    DIG_ZERO = 2'd0,
    DIG_NEG  = 2'd1,
    DIG_POS  = 2'd2
  } digit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_END
  } state_t;

  typedef enum logic {
    KIND_ARC = 1'b0,
    KIND_END = 1'b1
  } kind_t;

  typedef struct packed {
    logic keep;
    logic precedes;
    logic wrapped;
  } eval_flags_t;

endpackage
`default_nettype wire

// ===== src/tgnw_if.sv =====
// Valid/ready channel interfaces of the torus grid neighbour walker.
// Depends on tgnw_pkg for the result coordinate width.
`default_nettype none
interface tgnw_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface tgnw_out_if;
  import tgnw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   result_kind;
  logic [OUT_COORD_W-1:0] node_x;
  logic [OUT_COORD_W-1:0] node_y;
  logic [OUT_COORD_W-1:0] node_z;
  logic [OUT_COORD_W-1:0] neighbour_x;
  logic [OUT_COORD_W-1:0] neighbour_y;
  logic [OUT_COORD_W-1:0] neighbour_z;
  logic                   neighbour_precedes;
  logic                   wrapped;
  logic                   final_node;
  logic                   last_of_run;

  modport source (output valid, output result_kind, output node_x, output node_y,
                  output node_z, output neighbour_x, output neighbour_y,
                  output neighbour_z, output neighbour_precedes, output wrapped,
                  output final_node, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input node_x, input node_y,
                  input node_z, input neighbour_x, input neighbour_y,
                  input neighbour_z, input neighbour_precedes, input wrapped,
                  input final_node, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== src/tgnw_offset_eval.sv =====
// Shared offset evaluator: applies one offset vector to the current node.
// Depends on tgnw_pkg (digit_t, eval_flags_t).
`default_nettype none
module tgnw_offset_eval #(
  parameter int MAX_DIMS   = 3,
  parameter int COORD_BITS = 8
) (
  input  logic [MAX_DIMS-1:0]           dim_en,
  input  logic [COORD_BITS-1:0]         node [MAX_DIMS],
  input  tgnw_pkg::digit_t              digit [MAX_DIMS],
  input  logic [COORD_BITS:0]           n_m1,
  input  logic                          torus,
  input  logic [tgnw_pkg::DIST_W-1:0]   min_dist,
  input  logic [tgnw_pkg::DIST_W-1:0]   max_dist,
  output logic [COORD_BITS-1:0]         nbr [MAX_DIMS],
  output tgnw_pkg::eval_flags_t         flags
);
  import tgnw_pkg::*;

  localparam int J_W   = COORD_BITS + 2;
  localparam int CNT_W = $clog2(MAX_DIMS + 1);

  logic signed [J_W-1:0] step [MAX_DIMS];
  logic signed [J_W-1:0] j    [MAX_DIMS];
  logic [MAX_DIMS-1:0]   lo, hi, nz;
  logic                  off_grid, wrap_en, prec;
  logic [CNT_W-1:0]      nnz;

  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      unique case (digit[k])
        DIG_NEG: step[k] = -J_W'(1);
        DIG_POS: step[k] = J_W'(1);
        default: step[k] = '0;
      endcase
      j[k]  = $signed({2'b00, node[k]}) + step[k];
      lo[k] = dim_en[k] && (j[k] < 0);
      hi[k] = dim_en[k] && (j[k] > $signed({1'b0, n_m1}));
      nz[k] = dim_en[k] && (digit[k] != DIG_ZERO);
    end
    off_grid = |(lo | hi);
    wrap_en  = torus && off_grid;
    nnz      = CNT_W'($countones(nz));

    // in torus mode only the dims that leave the grid wrap; the others keep their step
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (!dim_en[k])          nbr[k] = '0;
      else if (wrap_en && lo[k]) nbr[k] = COORD_BITS'(n_m1);
      else if (wrap_en && hi[k]) nbr[k] = '0;
      else                     nbr[k] = COORD_BITS'(j[k]);
    end

    // highest differing dim decides; equal counts as preceding
    prec = 1'b1;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (dim_en[k] && (nbr[k] != node[k])) prec = (nbr[k] < node[k]);
    end

    flags.keep     = (torus || !off_grid) && (int'(nnz) >= int'(min_dist))
                     && (int'(nnz) <= int'(max_dist));
    flags.precedes = prec;
    flags.wrapped  = wrap_en;
  end

endmodule
`default_nettype wire

// ===== src/torus_grid_neighbour_walker_core.sv =====
// Top level of the torus grid neighbour walker: sequencer, node and offset
// state, config registers and result register. Depends on tgnw_pkg, tgnw_if,
// tgnw_offset_eval and the assertion macro header.
//
// Each input item (a tick) handles the current node of a grid with up to
// MAX_DIMS dimensions: it emits one arc item per kept neighbour offset
// (digits -1/+1/0, digit 0 fastest, all-zero excluded, nonzero count within
// [min_distance, max_distance], off-grid skipped in cube mode, wrapped in
// torus mode), then one end-of-node item, and advances the node like an
// odometer. After the last node the walker is done and ignores ticks until
// one with restart set. Order: the tick is taken in the idle state, then the
// sequencer visits one offset per cycle, while the result register can take
// an item, through the single offset evaluator, then the end state emits
// the end item; back pressure on the result register stalls the walk.
// in_ch.ready is high only between ticks. Config writes are taken any
// cycle but must only happen while the walker is idle.
`default_nettype none
`include "torus_grid_neighbour_walker_core_defines.svh"
module torus_grid_neighbour_walker_core #(
  parameter int MAX_DIMS   = 3,
  parameter int COORD_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tgnw_in_if.sink                        in_ch,
  tgnw_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tgnw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgnw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tgnw_pkg::*;

  localparam int N_W  = COORD_BITS + 1;
  localparam int MAXN = 1 << COORD_BITS;

  // config registers
  logic [DIMS_W-1:0] dims_r;
  logic [GRID_W-1:0] grid_r;
  logic              torus_r;
  logic [DIST_W-1:0] min_r, max_r;

  // walker state
  state_t                  state_r, state_nxt;
  logic [COORD_BITS-1:0]   node_r  [MAX_DIMS];
  logic [COORD_BITS-1:0]   node_nxt[MAX_DIMS];
  digit_t                  digit_r  [MAX_DIMS];
  digit_t                  digit_nxt[MAX_DIMS];
  logic                    done_r, done_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic [OUT_COORD_W-1:0] out_node_r [OUT_DIMS];
  logic [OUT_COORD_W-1:0] out_node_nxt[OUT_DIMS];
  logic [OUT_COORD_W-1:0] out_nbr_r  [OUT_DIMS];
  logic [OUT_COORD_W-1:0] out_nbr_nxt[OUT_DIMS];
  logic                   out_prec_r, out_prec_nxt;
  logic                   out_wrap_r, out_wrap_nxt;
  logic                   out_final_r, out_final_nxt;
  logic                   out_last_r, out_last_nxt;

  // datapath
  logic [MAX_DIMS-1:0]    dim_en;
  logic [N_W-1:0]         n_eff, n_m1;
  logic [COORD_BITS-1:0]  nbr [MAX_DIMS];
  eval_flags_t            flags;
  digit_t                 digit_adv[MAX_DIMS];
  logic                   digit_wrap;
  logic [COORD_BITS-1:0]  odo_node[MAX_DIMS];
  logic                   odo_carry;
  logic [OUT_COORD_W-1:0] node_pad[OUT_DIMS];
  logic [OUT_COORD_W-1:0] nbr_pad [OUT_DIMS];
  logic                   in_acc, out_free, tick_live, node_zero;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign tick_live = !done_r || in_ch.restart;
  assign in_ch.ready = (state_r == ST_IDLE);

  // dims 0 acts as 1, above MAX_DIMS as MAX_DIMS; grid size clamped to [1, 2^COORD_BITS]
  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) dim_en[k] = (k == 0) || (k < int'(dims_r));
    if (grid_r == '0)                n_eff = N_W'(1);
    else if (int'(grid_r) > MAXN)    n_eff = N_W'(MAXN);
    else                             n_eff = N_W'(grid_r);
    n_m1 = n_eff - N_W'(1);
  end

  tgnw_offset_eval #(
    .MAX_DIMS  (MAX_DIMS),
    .COORD_BITS(COORD_BITS)
  ) u_eval (
    .dim_en  (dim_en),
    .node    (node_r),
    .digit   (digit_r),
    .n_m1    (n_m1),
    .torus   (torus_r),
    .min_dist(min_r),
    .max_dist(max_r),
    .nbr     (nbr),
    .flags   (flags)
  );

  // offset odometer: -1 -> +1 -> 0 and carry; carry out of the top dim ends the walk
  always_comb begin
    digit_wrap = 1'b1;
    for (int k = 0; k < MAX_DIMS; k++) begin
      digit_adv[k] = digit_r[k];
      if (digit_wrap && dim_en[k]) begin
        unique case (digit_r[k])
          DIG_ZERO: begin
            digit_adv[k] = DIG_NEG;
            digit_wrap   = 1'b0;
          end
          DIG_NEG: begin
            digit_adv[k] = DIG_POS;
            digit_wrap   = 1'b0;
          end
          default: digit_adv[k] = DIG_ZERO;
        endcase
      end
    end
  end

  // node odometer; a coordinate at or past the edge goes to 0 and carries
  always_comb begin
    odo_carry = 1'b1;
    for (int k = 0; k < MAX_DIMS; k++) begin
      odo_node[k] = node_r[k];
      if (odo_carry && dim_en[k]) begin
        if (({1'b0, node_r[k]} + N_W'(1)) < n_eff) begin
          odo_node[k] = node_r[k] + COORD_BITS'(1);
          odo_carry   = 1'b0;
        end else begin
          odo_node[k] = '0;
        end
      end
    end
  end

  always_comb begin
    node_zero = 1'b1;
    for (int k = 0; k < MAX_DIMS; k++) if (node_r[k] != '0) node_zero = 1'b0;
  end

  // pad to the three result coordinate fields
  for (genvar g = 0; g < OUT_DIMS; g++) begin : g_pad
    if (g < MAX_DIMS) begin : g_used
      assign node_pad[g] = OUT_COORD_W'(node_r[g]);
      assign nbr_pad[g]  = OUT_COORD_W'(nbr[g]);
    end else begin : g_unused
      assign node_pad[g] = '0;
      assign nbr_pad[g]  = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && tick_live) state_nxt = ST_WALK;
      ST_WALK: if (out_free && digit_wrap) state_nxt = ST_END;
      ST_END:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result register updates
  always_comb begin
    node_nxt      = node_r;
    digit_nxt     = digit_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_node_nxt  = out_node_r;
    out_nbr_nxt   = out_nbr_r;
    out_prec_nxt  = out_prec_r;
    out_wrap_nxt  = out_wrap_r;
    out_final_nxt = out_final_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && tick_live) begin
          done_nxt = 1'b0;
          for (int k = 0; k < MAX_DIMS; k++) begin
            node_nxt[k]  = (in_ch.restart || !dim_en[k]) ? '0 : node_r[k];
            digit_nxt[k] = (k == 0) ? DIG_NEG : DIG_ZERO;
          end
        end
      end
      ST_WALK: begin
        if (out_free) begin
          digit_nxt = digit_adv;
          if (flags.keep) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_ARC;
            out_node_nxt  = node_pad;
            out_nbr_nxt   = nbr_pad;
            out_prec_nxt  = flags.precedes;
            out_wrap_nxt  = flags.wrapped;
            out_final_nxt = 1'b0;
            out_last_nxt  = 1'b0;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_END;
          out_node_nxt  = node_pad;
          for (int k = 0; k < OUT_DIMS; k++) out_nbr_nxt[k] = '0;
          out_prec_nxt  = 1'b0;
          out_wrap_nxt  = 1'b0;
          out_final_nxt = odo_carry;
          out_last_nxt  = 1'b1;
          node_nxt      = odo_node;
          done_nxt      = odo_carry;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      dims_r      <= DIMS_RST;
      grid_r      <= GRID_RST;
      torus_r     <= TORUS_RST;
      min_r       <= MIN_RST;
      max_r       <= MAX_RST;
      for (int k = 0; k < MAX_DIMS; k++) begin
        node_r[k]  <= '0;
        digit_r[k] <= (k == 0) ? DIG_NEG : DIG_ZERO;
      end
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      node_r      <= node_nxt;
      digit_r     <= digit_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIMS:  dims_r  <= cfg_wdata[DIMS_W-1:0];
          CFG_GRID:  grid_r  <= cfg_wdata[GRID_W-1:0];
          CFG_TORUS: torus_r <= cfg_wdata[0];
          CFG_MIN:   min_r   <= cfg_wdata[DIST_W-1:0];
          CFG_MAX:   max_r   <= cfg_wdata[DIST_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_node_r  <= out_node_nxt;
    out_nbr_r   <= out_nbr_nxt;
    out_prec_r  <= out_prec_nxt;
    out_wrap_r  <= out_wrap_nxt;
    out_final_r <= out_final_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.result_kind        = out_kind_r;
  assign out_ch.node_x             = out_node_r[0];
  assign out_ch.node_y             = out_node_r[1];
  assign out_ch.node_z             = out_node_r[2];
  assign out_ch.neighbour_x        = out_nbr_r[0];
  assign out_ch.neighbour_y        = out_nbr_r[1];
  assign out_ch.neighbour_z        = out_nbr_r[2];
  assign out_ch.neighbour_precedes = out_prec_r;
  assign out_ch.wrapped            = out_wrap_r;
  assign out_ch.final_node         = out_final_r;
  assign out_ch.last_of_run        = out_last_r;

  // finished grid parks the node at the origin
  `TGNW_ASSERT_SAME(a_done_at_origin, clk, rst_n, done_r, node_zero, "done with node off origin")
  // a tick on a finished grid without restart produces nothing
  `TGNW_ASSERT_NEXT(a_done_tick_idle, clk, rst_n, in_acc && done_r && !in_ch.restart, state_r == ST_IDLE, "tick after done started a walk")
  // the end item closes every walk
  `TGNW_ASSERT_NEXT(a_end_item, clk, rst_n, state_r == ST_END && out_free, state_r == ST_IDLE && out_valid_r && out_kind_r == KIND_END && out_last_r, "end item missing")
  // arc items never carry end flags
  `TGNW_ASSERT_SAME(a_arc_flags, clk, rst_n, out_valid_r && out_kind_r == KIND_ARC, !out_last_r && !out_final_r, "arc item with end flags")

endmodule
`default_nettype wire
